// ===== rtl/cpseg_pkg.sv =====
// ----------------------------------------------------------------------------
// cpseg_pkg
// Shared widths, beat types and mode codes of the closest-point-on-segment
// block.
// ----------------------------------------------------------------------------
package cpseg_pkg;

    localparam int CPS_W  = 16;             // coordinate width
    localparam int DW     = CPS_W + 1;      // delta width, exact
    localparam int PW     = 2 * DW;         // product / denominator width
    localparam int NW     = PW + 1;         // numerator width, signed
    localparam int QW     = DW;             // quotient width
    localparam int MW     = 3 * DW;         // dividend width
    localparam int QDEPTH = 2;              // front-to-back queue depth

    // Result selection
    localparam logic [1:0] MODE_NONE = 2'd0;   // zero-length segment
    localparam logic [1:0] MODE_A    = 2'd1;   // clamp to A
    localparam logic [1:0] MODE_B    = 2'd2;   // clamp to B
    localparam logic [1:0] MODE_MID  = 2'd3;   // interpolate

    typedef struct packed {
        logic signed [CPS_W-1:0] point_x;
        logic signed [CPS_W-1:0] point_y;
        logic signed [CPS_W-1:0] seg_a_x;
        logic signed [CPS_W-1:0] seg_a_y;
        logic signed [CPS_W-1:0] seg_b_x;
        logic signed [CPS_W-1:0] seg_b_y;
    } t_in;

    typedef struct packed {
        logic                    valid_res;
        logic signed [CPS_W-1:0] closest_x;
        logic signed [CPS_W-1:0] closest_y;
    } t_out;

    // Classified work item handed from front to back
    typedef struct packed {
        logic [1:0]              mode;
        logic signed [DW-1:0]    pa_x;
        logic signed [DW-1:0]    pa_y;
        logic signed [DW-1:0]    d_x;
        logic signed [DW-1:0]    d_y;
        logic signed [CPS_W-1:0] a_x;
        logic signed [CPS_W-1:0] a_y;
        logic signed [CPS_W-1:0] b_x;
        logic signed [CPS_W-1:0] b_y;
    } t_job;

    // Context carried alongside the arithmetic in the back pipeline
    typedef struct packed {
        logic [1:0]              mode;
        logic signed [CPS_W-1:0] a_x;
        logic signed [CPS_W-1:0] a_y;
        logic signed [CPS_W-1:0] b_x;
        logic signed [CPS_W-1:0] b_y;
        logic                    neg_x;
        logic                    neg_y;
        logic [DW-1:0]           mag_x;
        logic [DW-1:0]           mag_y;
    } t_ctx;

endpackage

// ===== rtl/closest_point_on_segment.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_segment
// Nearest point on segment AB to query point P, exact fixed-point math.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while o_stall is low and returns one result
// beat per input beat, in order. With an empty queue, the path from input
// accept to output valid is: the front register loads at the accepting
// edge, then come the queue write, four arithmetic stages, the divider head
// register, one stage per quotient bit of the pipelined restoring divider
// (coordinate width plus one), and the output register. The divider
// pipeline sets the latency; throughput is one beat per cycle as long as
// the output side does not stall. When the output stalls, the whole back
// pipeline holds, the two-entry queue fills, and then the front raises
// o_stall. A zero-length segment returns valid_res = 0 with both
// coordinates zero. The result is A when the projection falls before A, B
// when it falls past B, and otherwise A + (B-A)*n/d with the quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
module closest_point_on_segment (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  cpseg_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output cpseg_pkg::t_out  o_data
);
    import cpseg_pkg::*;

    // front -> queue
    logic f_valid;
    logic q_full;
    t_job f_job;
    // queue -> back
    logic q_valid;
    logic b_pop;
    t_job q_job;

    // Classify: deltas and zero-length check.
    cpseg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (f_valid),
        .i_full  (q_full),
        .o_job   (f_job)
    );

    // Decouple: the two-entry queue lets the front keep taking beats
    // while the back holds.
    cpseg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Compute: dot products, clamp, divide, select.
    cpseg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (b_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== rtl/cpseg_front.sv =====
// ----------------------------------------------------------------------------
// cpseg_front
// Input stage: takes a beat, forms the deltas and flags zero-length segments.
// ----------------------------------------------------------------------------
module cpseg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cpseg_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_full,
    output cpseg_pkg::t_job o_job
);
    import cpseg_pkg::*;

    logic r_fv;
    t_job r_job;
    t_job n_job;
    logic advance;

    assign advance = !r_fv || !i_full;
    assign o_stall = !advance;
    assign o_valid = r_fv;
    assign o_job   = r_job;

    always_comb begin
        n_job.a_x  = i_data.seg_a_x;
        n_job.a_y  = i_data.seg_a_y;
        n_job.b_x  = i_data.seg_b_x;
        n_job.b_y  = i_data.seg_b_y;
        n_job.d_x  = DW'(i_data.seg_b_x) - DW'(i_data.seg_a_x);
        n_job.d_y  = DW'(i_data.seg_b_y) - DW'(i_data.seg_a_y);
        n_job.pa_x = DW'(i_data.point_x) - DW'(i_data.seg_a_x);
        n_job.pa_y = DW'(i_data.point_y) - DW'(i_data.seg_a_y);
        n_job.mode = (n_job.d_x == '0 && n_job.d_y == '0) ? MODE_NONE : MODE_MID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (advance) begin
            r_fv <= i_valid;
        end
        if (advance) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== rtl/cpseg_queue.sv =====
// ----------------------------------------------------------------------------
// cpseg_queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module cpseg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpseg_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cpseg_pkg::t_job o_job
);
    import cpseg_pkg::*;

    localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);

    t_job            r_mem [QDEPTH];
    logic [PTRW-1:0] r_wp;
    logic [PTRW-1:0] r_rp;
    logic [CNTW-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_full  = (r_cnt == CNTW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTRW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTRW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== rtl/cpseg_back.sv =====
// ----------------------------------------------------------------------------
// cpseg_back
// Arithmetic pipeline: products, dot sums, clamp decision, scaled numerator,
// one quotient bit per stage, final select into the output register.
// ----------------------------------------------------------------------------
module cpseg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cpseg_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output cpseg_pkg::t_out o_data
);
    import cpseg_pkg::*;

    logic en;

    // stage 1: products
    logic                 r1_v;
    t_ctx                 r1_ctx;
    logic signed [PW-1:0] r1_pdx, r1_pdy, r1_sqx, r1_sqy;
    // stage 2: numerator and denominator
    logic                 r2_v;
    t_ctx                 r2_ctx;
    logic signed [NW-1:0] r2_num;
    logic [PW-1:0]        r2_den;
    // stage 3: clamp decision and partial products
    logic                 r3_v;
    t_ctx                 r3_ctx;
    logic [PW-1:0]        r3_den;
    logic [PW-1:0]        r3_xl, r3_xh, r3_yl, r3_yh;
    // stage 4: full dividends
    logic                 r4_v;
    t_ctx                 r4_ctx;
    logic [PW-1:0]        r4_den;
    logic [MW-1:0]        r4_nx, r4_ny;
    // divider stages
    logic                 r_dv_v   [QW+1];
    t_ctx                 r_dv_ctx [QW+1];
    logic [PW-1:0]        r_dv_den [QW+1];
    logic [PW-1:0]        r_rx     [QW+1];
    logic [PW-1:0]        r_ry     [QW+1];
    logic [QW-1:0]        r_lx     [QW+1];
    logic [QW-1:0]        r_ly     [QW+1];
    logic [QW-1:0]        r_qx     [QW+1];
    logic [QW-1:0]        r_qy     [QW+1];
    // output
    logic                 r_out_v;
    t_out                 r_out;
    t_out                 n_out;

    t_ctx                 n1_ctx;
    t_ctx                 n3_ctx;
    logic [PW-1:0]        nu;
    t_ctx                 fc;
    logic [DW-1:0]        sx, sy;

    // Advance the whole pipe whenever the output slot frees up.
    assign en      = !r_out_v || !i_stall;
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_comb begin
        n1_ctx.mode  = i_job.mode;
        n1_ctx.a_x   = i_job.a_x;
        n1_ctx.a_y   = i_job.a_y;
        n1_ctx.b_x   = i_job.b_x;
        n1_ctx.b_y   = i_job.b_y;
        n1_ctx.neg_x = i_job.d_x[DW-1];
        n1_ctx.neg_y = i_job.d_y[DW-1];
        n1_ctx.mag_x = i_job.d_x[DW-1] ? DW'(-i_job.d_x) : DW'(i_job.d_x);
        n1_ctx.mag_y = i_job.d_y[DW-1] ? DW'(-i_job.d_y) : DW'(i_job.d_y);
    end

    always_comb begin
        n3_ctx = r2_ctx;
        if (r2_ctx.mode == MODE_MID) begin
            if (r2_num[NW-1]) begin
                n3_ctx.mode = MODE_A;
            end else if (r2_num > $signed({1'b0, r2_den})) begin
                n3_ctx.mode = MODE_B;
            end
        end
        nu = r2_num[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
        if (en) begin
            r1_ctx <= n1_ctx;
            r1_pdx <= PW'(i_job.pa_x) * PW'(i_job.d_x);
            r1_pdy <= PW'(i_job.pa_y) * PW'(i_job.d_y);
            r1_sqx <= PW'(i_job.d_x) * PW'(i_job.d_x);
            r1_sqy <= PW'(i_job.d_y) * PW'(i_job.d_y);

            r2_ctx <= r1_ctx;
            r2_num <= NW'(r1_pdx) + NW'(r1_pdy);
            r2_den <= PW'(r1_sqx) + PW'(r1_sqy);

            r3_ctx <= n3_ctx;
            r3_den <= r2_den;
            r3_xl <= PW'(r2_ctx.mag_x) * PW'(nu[DW-1:0]);
            r3_xh <= PW'(r2_ctx.mag_x) * PW'(nu[PW-1:DW]);
            r3_yl <= PW'(r2_ctx.mag_y) * PW'(nu[DW-1:0]);
            r3_yh <= PW'(r2_ctx.mag_y) * PW'(nu[PW-1:DW]);

            r4_ctx <= r3_ctx;
            r4_den <= r3_den;
            r4_nx  <= (MW'(r3_xh) << DW) + MW'(r3_xl);
            r4_ny  <= (MW'(r3_yh) << DW) + MW'(r3_yl);
        end
    end

    // Divider head: top of the dividend seeds the remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r4_v;
        end
        if (en) begin
            r_dv_ctx[0] <= r4_ctx;
            r_dv_den[0] <= r4_den;
            r_rx[0]     <= r4_nx[MW-1:QW];
            r_ry[0]     <= r4_ny[MW-1:QW];
            r_lx[0]     <= r4_nx[QW-1:0];
            r_ly[0]     <= r4_ny[QW-1:0];
            r_qx[0]     <= '0;
            r_qy[0]     <= '0;
        end
    end

    // One restoring step per stage, both axes side by side.
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [PW:0] cx, cy;
        logic        gx, gy;

        always_comb begin
            cx = {r_rx[k], r_lx[k][QW-1]};
            cy = {r_ry[k], r_ly[k][QW-1]};
            gx = cx >= {1'b0, r_dv_den[k]};
            gy = cy >= {1'b0, r_dv_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            if (en) begin
                r_dv_ctx[k+1] <= r_dv_ctx[k];
                r_dv_den[k+1] <= r_dv_den[k];
                r_rx[k+1] <= gx ? PW'(cx - {1'b0, r_dv_den[k]}) : PW'(cx);
                r_ry[k+1] <= gy ? PW'(cy - {1'b0, r_dv_den[k]}) : PW'(cy);
                r_lx[k+1] <= r_lx[k] << 1;
                r_ly[k+1] <= r_ly[k] << 1;
                r_qx[k+1] <= {r_qx[k][QW-2:0], gx};
                r_qy[k+1] <= {r_qy[k][QW-2:0], gy};
            end
        end
    end

    always_comb begin
        fc = r_dv_ctx[QW];
        sx = fc.neg_x ? DW'(fc.a_x) - r_qx[QW] : DW'(fc.a_x) + r_qx[QW];
        sy = fc.neg_y ? DW'(fc.a_y) - r_qy[QW] : DW'(fc.a_y) + r_qy[QW];
        n_out.valid_res = 1'b1;
        unique case (fc.mode)
            MODE_NONE: begin
                n_out.valid_res = 1'b0;
                n_out.closest_x = '0;
                n_out.closest_y = '0;
            end
            MODE_A: begin
                n_out.closest_x = fc.a_x;
                n_out.closest_y = fc.a_y;
            end
            MODE_B: begin
                n_out.closest_x = fc.b_x;
                n_out.closest_y = fc.b_y;
            end
            default: begin
                n_out.closest_x = sx[CPS_W-1:0];
                n_out.closest_y = sy[CPS_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[QW];
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    // The interpolated step never overshoots the segment.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_v[QW] && r_dv_ctx[QW].mode == MODE_MID |->
            r_qx[QW] <= r_dv_ctx[QW].mag_x && r_qy[QW] <= r_dv_ctx[QW].mag_y)
        else $error("quotient exceeds segment delta");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_dv_v[QW] |=> r_out_v)
        else $error("finished item lost before output register");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out.valid_res |-> r_out.closest_x == '0 && r_out.closest_y == '0)
        else $error("degenerate segment with nonzero point");

endmodule
